FILE: rtl/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg: shared types and constants for the ray / triangle intersect block
// widths of the fixed point datapath, register indexes and item structs
// ----------------------------------------------------------------------------
package rti_pkg;

  // field widths
  localparam int COORD_W       = 32;
  localparam int TAG_W         = 16;
  localparam int DIST_W        = 31;
  localparam int BARY_W        = 16;
  localparam int FRAC_BITS_DEF = 16;

  // datapath widths
  localparam int DIFF_W  = COORD_W + 1;        // vertex difference
  localparam int PROD_W  = 2 * DIFF_W;         // 2x2 minor product
  localparam int MINOR_W = PROD_W + 1;         // 2x2 minor
  localparam int LO_W    = 33;                 // low split of a minor
  localparam int HI_W    = MINOR_W - LO_W;     // high split of a minor
  localparam int PP_W    = DIFF_W + HI_W;      // partial product
  localparam int DET_W   = DIFF_W + MINOR_W + 3; // 3x3 determinant with margin

  // stream widths
  localparam int IN_W  = 9 * COORD_W + TAG_W;
  localparam int OUT_W = 80;

  // input queue
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  // configuration registers
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [COORD_W-1:0] DIR_Z_RESET = 32'h0001_0000;

  typedef struct packed {
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [COORD_W-1:0] oz;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [COORD_W-1:0] dz;
  } ray_t;

  // edge vectors and origin offset of one triangle
  typedef struct packed {
    logic [DIFF_W-1:0] a;
    logic [DIFF_W-1:0] b;
    logic [DIFF_W-1:0] c;
    logic [DIFF_W-1:0] d;
    logic [DIFF_W-1:0] e;
    logic [DIFF_W-1:0] f;
    logic [DIFF_W-1:0] j;
    logic [DIFF_W-1:0] k;
    logic [DIFF_W-1:0] l;
    logic [TAG_W-1:0]  tag;
  } facet_t;

endpackage

FILE: rtl/rti_front.sv
// ----------------------------------------------------------------------------
// rti_front: triangle intake
// accepts a triangle item and registers its edge vectors and origin offset
// ----------------------------------------------------------------------------
module rti_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [rti_pkg::IN_W-1:0] s_tdata,
  input  rti_pkg::ray_t          ray,
  output logic                   facet_valid,
  input  logic                   facet_ready,
  output rti_pkg::facet_t        facet
);
  import rti_pkg::*;

  logic signed [COORD_W-1:0] v0x, v0y, v0z, v1x, v1y, v1z, v2x, v2y, v2z;

  // unpack vertices
  assign v0x = s_tdata[0*COORD_W +: COORD_W];
  assign v0y = s_tdata[1*COORD_W +: COORD_W];
  assign v0z = s_tdata[2*COORD_W +: COORD_W];
  assign v1x = s_tdata[3*COORD_W +: COORD_W];
  assign v1y = s_tdata[4*COORD_W +: COORD_W];
  assign v1z = s_tdata[5*COORD_W +: COORD_W];
  assign v2x = s_tdata[6*COORD_W +: COORD_W];
  assign v2y = s_tdata[7*COORD_W +: COORD_W];
  assign v2z = s_tdata[8*COORD_W +: COORD_W];

  assign s_tready = !facet_valid || facet_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      facet_valid <= 1'b0;
    end else if (s_tready) begin
      facet_valid <= s_tvalid;
    end
  end

  // edge differences
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      facet.a   <= DIFF_W'(v0x) - DIFF_W'(v1x);
      facet.b   <= DIFF_W'(v0y) - DIFF_W'(v1y);
      facet.c   <= DIFF_W'(v0z) - DIFF_W'(v1z);
      facet.d   <= DIFF_W'(v0x) - DIFF_W'(v2x);
      facet.e   <= DIFF_W'(v0y) - DIFF_W'(v2y);
      facet.f   <= DIFF_W'(v0z) - DIFF_W'(v2z);
      facet.j   <= DIFF_W'(v0x) - DIFF_W'($signed(ray.ox));
      facet.k   <= DIFF_W'(v0y) - DIFF_W'($signed(ray.oy));
      facet.l   <= DIFF_W'(v0z) - DIFF_W'($signed(ray.oz));
      facet.tag <= s_tdata[9*COORD_W +: TAG_W];
    end
  end

endmodule

FILE: rtl/rti_queue.sv
// ----------------------------------------------------------------------------
// rti_queue: small item queue
// decouples the intake from the arithmetic pipeline
// ----------------------------------------------------------------------------
module rti_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rti_pkg::facet_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output rti_pkg::facet_t out_item
);
  import rti_pkg::*;

  facet_t           mem [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign in_ready  = count != (PTR_W+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

endmodule

FILE: rtl/rti_back.sv
// ----------------------------------------------------------------------------
// rti_back: intersection pipeline
// minors, determinants, hit test and restoring division, one item per stage
// ----------------------------------------------------------------------------
module rti_back #(
  parameter int COORD_FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rti_pkg::ray_t            ray,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  rti_pkg::facet_t          q_item,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [rti_pkg::OUT_W-1:0] m_tdata,   // distance, bary_beta, bary_gamma, result_tag
  output logic [0:0]               m_tuser     // hit
);
  import rti_pkg::*;

  localparam int SH    = DIST_W - COORD_FRAC_BITS;
  localparam int RD_W  = DET_W + SH + 1;
  localparam int NSTEP = DIST_W;
  localparam int NTERM = 12;

  logic en;
  logic signed [DIFF_W-1:0] g, h, i;

  assign en      = !m_tvalid || m_tready;
  assign q_ready = en;
  assign g = DIFF_W'($signed(ray.dx));
  assign h = DIFF_W'($signed(ray.dy));
  assign i = DIFF_W'($signed(ray.dz));

  // stage valids
  logic v1, v2, v3, v4, v5, v6;
  logic vld [0:NSTEP];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else if (en) begin
      v1 <= q_valid; v2 <= v1; v3 <= v2;
      v4 <= v3; v5 <= v4; v6 <= v5;
    end
  end

  // stage 1: products for the 2x2 minors
  facet_t s1_f;
  logic signed [PROD_W-1:0] s1_ei, s1_hf, s1_gf, s1_di, s1_dh, s1_eg;
  logic signed [PROD_W-1:0] s1_ak, s1_jb, s1_jc, s1_al, s1_bl, s1_kc;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_f  <= q_item;
      s1_ei <= $signed(q_item.e) * i;
      s1_hf <= h * $signed(q_item.f);
      s1_gf <= g * $signed(q_item.f);
      s1_di <= $signed(q_item.d) * i;
      s1_dh <= $signed(q_item.d) * h;
      s1_eg <= $signed(q_item.e) * g;
      s1_ak <= $signed(q_item.a) * $signed(q_item.k);
      s1_jb <= $signed(q_item.j) * $signed(q_item.b);
      s1_jc <= $signed(q_item.j) * $signed(q_item.c);
      s1_al <= $signed(q_item.a) * $signed(q_item.l);
      s1_bl <= $signed(q_item.b) * $signed(q_item.l);
      s1_kc <= $signed(q_item.k) * $signed(q_item.c);
    end
  end

  // stage 2: minors
  facet_t s2_f;
  logic signed [MINOR_W-1:0] m1, m2, m3, n1, n2, n3;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_f <= s1_f;
      m1 <= MINOR_W'(s1_ei) - MINOR_W'(s1_hf);
      m2 <= MINOR_W'(s1_gf) - MINOR_W'(s1_di);
      m3 <= MINOR_W'(s1_dh) - MINOR_W'(s1_eg);
      n1 <= MINOR_W'(s1_ak) - MINOR_W'(s1_jb);
      n2 <= MINOR_W'(s1_jc) - MINOR_W'(s1_al);
      n3 <= MINOR_W'(s1_bl) - MINOR_W'(s1_kc);
    end
  end

  // stage 3: split partial products of the determinant terms
  logic signed [DIFF_W-1:0]  xa [0:NTERM-1];
  logic signed [MINOR_W-1:0] yb [0:NTERM-1];
  logic signed [PP_W-1:0]    s3_lo [0:NTERM-1];
  logic signed [PP_W-1:0]    s3_hi [0:NTERM-1];
  logic [TAG_W-1:0]          s3_tag;

  assign xa[0]  = $signed(s2_f.a); assign yb[0]  = m1;
  assign xa[1]  = $signed(s2_f.b); assign yb[1]  = m2;
  assign xa[2]  = $signed(s2_f.c); assign yb[2]  = m3;
  assign xa[3]  = $signed(s2_f.j); assign yb[3]  = m1;
  assign xa[4]  = $signed(s2_f.k); assign yb[4]  = m2;
  assign xa[5]  = $signed(s2_f.l); assign yb[5]  = m3;
  assign xa[6]  = i;               assign yb[6]  = n1;
  assign xa[7]  = h;               assign yb[7]  = n2;
  assign xa[8]  = g;               assign yb[8]  = n3;
  assign xa[9]  = $signed(s2_f.f); assign yb[9]  = n1;
  assign xa[10] = $signed(s2_f.e); assign yb[10] = n2;
  assign xa[11] = $signed(s2_f.d); assign yb[11] = n3;

  for (genvar n = 0; n < NTERM; n++) begin : g_pp
    always_ff @(posedge clk) begin
      if (en) begin
        s3_lo[n] <= xa[n] * $signed({1'b0, yb[n][LO_W-1:0]});
        s3_hi[n] <= xa[n] * $signed(yb[n][MINOR_W-1:LO_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) s3_tag <= s2_f.tag;
  end

  // stage 4: recombine terms
  logic signed [DET_W-1:0] s4_t [0:NTERM-1];
  logic [TAG_W-1:0]        s4_tag;

  for (genvar n = 0; n < NTERM; n++) begin : g_term
    always_ff @(posedge clk) begin
      if (en) s4_t[n] <= (DET_W'(s3_hi[n]) <<< LO_W) + DET_W'(s3_lo[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) s4_tag <= s3_tag;
  end

  // stage 5: determinants
  logic signed [DET_W-1:0] s5_den, s5_nb, s5_ng, s5_nt;
  logic [TAG_W-1:0]        s5_tag;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_den <= s4_t[0] + s4_t[1] + s4_t[2];
      s5_nb  <= s4_t[3] + s4_t[4] + s4_t[5];
      s5_ng  <= s4_t[6] + s4_t[7] + s4_t[8];
      s5_nt  <= -(s4_t[9] + s4_t[10] + s4_t[11]);
      s5_tag <= s4_tag;
    end
  end

  // stage 6: make the determinant non-negative
  logic signed [DET_W-1:0] s6_den, s6_nb, s6_ng, s6_nt;
  logic                    s6_dz;
  logic [TAG_W-1:0]        s6_tag;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_dz  <= s5_den == '0;
      s6_tag <= s5_tag;
      if (s5_den[DET_W-1]) begin
        s6_den <= -s5_den; s6_nb <= -s5_nb; s6_ng <= -s5_ng; s6_nt <= -s5_nt;
      end else begin
        s6_den <= s5_den; s6_nb <= s5_nb; s6_ng <= s5_ng; s6_nt <= s5_nt;
      end
    end
  end

  // stage 7: hit test, saturation and division setup
  logic [RD_W-1:0]   dr   [0:NSTEP];
  logic [DET_W-1:0]  br   [0:NSTEP];
  logic [DET_W-1:0]  gr   [0:NSTEP];
  logic [DET_W-1:0]  dv   [0:NSTEP];
  logic [DIST_W-1:0] qd   [0:NSTEP];
  logic [BARY_W-1:0] qb   [0:NSTEP];
  logic [BARY_W-1:0] qg   [0:NSTEP];
  logic              hitp [0:NSTEP];
  logic              satp [0:NSTEP];
  logic [TAG_W-1:0]  tagp [0:NSTEP];

  logic nb_pos, ng_pos, nt_pos, nb_lt, sum_lt, sat;

  assign nb_pos = s6_nb > 0;
  assign ng_pos = s6_ng > 0;
  assign nt_pos = s6_nt > 0;
  assign nb_lt  = s6_nb < s6_den;
  assign sum_lt = (s6_nb + s6_ng) < s6_den;
  assign sat    = RD_W'(s6_nt) >= (RD_W'(s6_den) <<< SH);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hitp[0] <= !s6_dz && nb_pos && nb_lt && ng_pos && sum_lt && nt_pos;
      satp[0] <= sat;
      tagp[0] <= s6_tag;
      dr[0]   <= RD_W'(s6_nt);
      br[0]   <= s6_nb;
      gr[0]   <= s6_ng;
      dv[0]   <= s6_den;
      qd[0]   <= '0;
      qb[0]   <= '0;
      qg[0]   <= '0;
    end
  end

  // restoring division, one distance quotient bit per stage; barycentric bits in the first BARY_W stages
  for (genvar s = 0; s < NSTEP; s++) begin : g_div
    logic [RD_W-1:0]  dsh, dtwo;
    logic [DET_W-1:0] btwo, gtwo;

    assign dsh  = RD_W'(dv[s]) << SH;
    assign dtwo = {dr[s][RD_W-2:0], 1'b0};
    assign btwo = {br[s][DET_W-2:0], 1'b0};
    assign gtwo = {gr[s][DET_W-2:0], 1'b0};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hitp[s+1] <= hitp[s];
        satp[s+1] <= satp[s];
        tagp[s+1] <= tagp[s];
        dv[s+1]   <= dv[s];
        if (dtwo >= dsh) begin
          dr[s+1] <= dtwo - dsh;
          qd[s+1] <= {qd[s][DIST_W-2:0], 1'b1};
        end else begin
          dr[s+1] <= dtwo;
          qd[s+1] <= {qd[s][DIST_W-2:0], 1'b0};
        end
      end
    end

    if (s < BARY_W) begin : g_bary
      always_ff @(posedge clk) begin
        if (en) begin
          if (btwo >= dv[s]) begin
            br[s+1] <= btwo - dv[s];
            qb[s+1] <= {qb[s][BARY_W-2:0], 1'b1};
          end else begin
            br[s+1] <= btwo;
            qb[s+1] <= {qb[s][BARY_W-2:0], 1'b0};
          end
          if (gtwo >= dv[s]) begin
            gr[s+1] <= gtwo - dv[s];
            qg[s+1] <= {qg[s][BARY_W-2:0], 1'b1};
          end else begin
            gr[s+1] <= gtwo;
            qg[s+1] <= {qg[s][BARY_W-2:0], 1'b0};
          end
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          br[s+1] <= br[s];
          gr[s+1] <= gr[s];
          qb[s+1] <= qb[s];
          qg[s+1] <= qg[s];
        end
      end
    end
  end

  // output register
  logic [DIST_W-1:0] dist_out;
  assign dist_out = satp[NSTEP] ? '1 : qd[NSTEP];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= hitp[NSTEP];
      if (hitp[NSTEP]) begin
        m_tdata <= {1'b0, tagp[NSTEP], qg[NSTEP], qb[NSTEP], dist_out};
      end else begin
        m_tdata <= {1'b0, tagp[NSTEP], {BARY_W{1'b0}}, {BARY_W{1'b0}}, {DIST_W{1'b0}}};
      end
    end
  end

endmodule

FILE: rtl/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect: ray / triangle hit test by Cramer's rule
// one ray held in registers, a stream of triangles in, one result per triangle
// ----------------------------------------------------------------------------
//  channel   direction  handshake            content
//  s_axis    in         s_tvalid / s_tready  triangle item (vertices, tag)
//  m_axis    out        m_tvalid / m_tready  result item (hit, distance, bary)
//  cfg       in         cfg_valid/cfg_ready  ray register writes
//
//  one triangle per cycle sustained while the output is not stalled; the path
//  from input accept to result valid is mostly the 31 stage restoring divider
//  for the distance. synchronous reset clears the ray to origin 0, direction
//  +z (1.0). a stalled output holds the whole arithmetic pipeline; the four
//  entry input queue keeps taking items until it fills.
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
  parameter int COORD_FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [rti_pkg::IN_W-1:0]  s_tdata,   // vertex0_x/y/z, vertex1_x/y/z, vertex2_x/y/z, triangle_tag
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [rti_pkg::OUT_W-1:0] m_tdata,   // distance, bary_beta, bary_gamma, result_tag
  output logic [0:0]                m_tuser,   // hit
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rti_pkg::IDX_W-1:0] cfg_index,
  input  logic [rti_pkg::COORD_W-1:0] cfg_data
);
  import rti_pkg::*;

  ray_t   ray;
  facet_t fr_item, q_item;
  logic   fr_valid, fr_ready, q_valid, q_ready;

  assign cfg_ready = 1'b1;

  // ray registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ray.ox <= '0; ray.oy <= '0; ray.oz <= '0;
      ray.dx <= '0; ray.dy <= '0; ray.dz <= DIR_Z_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X: ray.ox <= cfg_data;
        REG_ORIGIN_Y: ray.oy <= cfg_data;
        REG_ORIGIN_Z: ray.oz <= cfg_data;
        REG_DIR_X:    ray.dx <= cfg_data;
        REG_DIR_Y:    ray.dy <= cfg_data;
        REG_DIR_Z:    ray.dz <= cfg_data;
        default:      ray <= ray;
      endcase
    end
  end

  rti_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .ray         (ray),
    .facet_valid (fr_valid),
    .facet_ready (fr_ready),
    .facet       (fr_item)
  );

  rti_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_item   (fr_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  rti_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .ray      (ray),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: dv/ray_triangle_intersect_test.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect_test: self-checking bench for the ray / triangle block
// streams triangles against several ray settings, predicts each outcome with
// exact wide integer Cramer's rule and compares every result item in order
// ----------------------------------------------------------------------------
module ray_triangle_intersect_test;
  import rti_pkg::*;

  localparam int COORD_FRAC_BITS_TB = FRAC_BITS_DEF;
  localparam int ONE = 65536;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic              hit;
    logic [DIST_W-1:0] distance;
    logic [BARY_W-1:0] beta;
    logic [BARY_W-1:0] gamma;
    logic [TAG_W-1:0]  tag;
  } outcome_t;

  // in-order outcome tracker with its own copy of the ray
  class hit_scoreboard;
    logic [COORD_W-1:0] ray_reg[6];
    outcome_t           outcomes[$];
    int                 errors;

    function new();
      errors = 0;
      reset_ray();
    endfunction

    function void reset_ray();
      foreach (ray_reg[n]) ray_reg[n] = '0;
      ray_reg[REG_DIR_Z] = DIR_Z_RESET;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] val);
      if (idx <= REG_DIR_Z) ray_reg[idx] = val;
    endfunction

    function wide_t sx(logic [COORD_W-1:0] v);
      return wide_t'($signed(v));
    endfunction

    // cramer's rule on the accepted triangle
    function void note_triangle(logic [IN_W-1:0] data);
      wide_t p[9];
      wide_t a, b, c, d, e, f, g, h, i, j, k, l;
      wide_t m1, m2, m3, n1, n2, n3, den, nb, ng, nt, q;
      outcome_t o;
      for (int n = 0; n < 9; n++) p[n] = sx(data[n*COORD_W +: COORD_W]);
      o = '{hit: 1'b0, distance: '0, beta: '0, gamma: '0,
            tag: data[9*COORD_W +: TAG_W]};
      a = p[0] - p[3]; b = p[1] - p[4]; c = p[2] - p[5];
      d = p[0] - p[6]; e = p[1] - p[7]; f = p[2] - p[8];
      g = sx(ray_reg[REG_DIR_X]); h = sx(ray_reg[REG_DIR_Y]); i = sx(ray_reg[REG_DIR_Z]);
      j = p[0] - sx(ray_reg[REG_ORIGIN_X]);
      k = p[1] - sx(ray_reg[REG_ORIGIN_Y]);
      l = p[2] - sx(ray_reg[REG_ORIGIN_Z]);
      m1 = e*i - h*f; m2 = g*f - d*i; m3 = d*h - e*g;
      n1 = a*k - j*b; n2 = j*c - a*l; n3 = b*l - k*c;
      den = a*m1 + b*m2 + c*m3;
      nb  = j*m1 + k*m2 + l*m3;
      ng  = i*n1 + h*n2 + g*n3;
      nt  = -(f*n1 + e*n2 + d*n3);
      if (den < 0) begin
        den = -den; nb = -nb; ng = -ng; nt = -nt;
      end
      if (den != 0 && nb > 0 && nb < den && ng > 0 && nb + ng < den && nt > 0) begin
        o.hit = 1'b1;
        q = (nt <<< COORD_FRAC_BITS_TB) / den;
        o.distance = (q > wide_t'(32'h7FFF_FFFF)) ? {DIST_W{1'b1}} : q[DIST_W-1:0];
        q = (nb <<< BARY_W) / den;
        o.beta = (q > 65535) ? 16'hFFFF : q[BARY_W-1:0];
        q = (ng <<< BARY_W) / den;
        o.gamma = (q > 65535) ? 16'hFFFF : q[BARY_W-1:0];
      end
      outcomes.push_back(o);
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic hit);
      outcome_t o;
      if (outcomes.size() == 0) begin
        $error("result item with nothing outstanding");
        errors++;
        return;
      end
      o = outcomes.pop_front();
      if (hit !== o.hit) begin
        $error("hit: expected %0d actual %0d", o.hit, hit); errors++;
      end
      if (data[30:0] !== o.distance) begin
        $error("distance: expected %0h actual %0h", o.distance, data[30:0]); errors++;
      end
      if (data[46:31] !== o.beta) begin
        $error("bary_beta: expected %0h actual %0h", o.beta, data[46:31]); errors++;
      end
      if (data[62:47] !== o.gamma) begin
        $error("bary_gamma: expected %0h actual %0h", o.gamma, data[62:47]); errors++;
      end
      if (data[78:63] !== o.tag) begin
        $error("result_tag: expected %0h actual %0h", o.tag, data[78:63]); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [IN_W-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_valid, cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0] cfg_data;

  hit_scoreboard sb;
  bit quiet;                         // no idling on either side
  int ray_o[3], ray_d[3];            // ray as currently programmed

  ray_triangle_intersect DUT (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // monitors: config writes, accepted triangles, results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_triangle(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= quiet || ($urandom_range(99) >= 6);
  end

  task automatic send_triangle(int v[9], logic [TAG_W-1:0] tag);
    logic [IN_W-1:0] data;
    for (int n = 0; n < 9; n++) data[n*COORD_W +: COORD_W] = v[n];
    data[9*COORD_W +: TAG_W] = tag;
    if (!quiet && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_ray_reg(logic [IDX_W-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= REG_DIR_Z) begin
      if (idx < REG_DIR_X) ray_o[idx] = val;
      else ray_d[idx - REG_DIR_X] = val;
    end
  endtask

  // drain, then sit out the pipeline before touching the ray
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outcomes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    drain();
    write_ray_reg(REG_ORIGIN_X, ox);
    write_ray_reg(REG_ORIGIN_Y, oy);
    write_ray_reg(REG_ORIGIN_Z, oz);
    write_ray_reg(REG_DIR_X, dx);
    write_ray_reg(REG_DIR_Y, dy);
    write_ray_reg(REG_DIR_Z, dz);
    // out of range indexes must be dropped
    write_ray_reg(3'd6, $urandom);
    write_ray_reg(3'd7, $urandom);
  endtask

  task automatic tri_q(int x0, int y0, int z0, int x1, int y1, int z1,
                       int x2, int y2, int z2, logic [TAG_W-1:0] tag);
    int v[9];
    v = '{x0, y0, z0, x1, y1, z1, x2, y2, z2};
    send_triangle(v, tag);
  endtask

  // mostly triangles built around a point on the ray, the rest noise
  task automatic random_triangles(int count);
    int v[9];
    longint pt[3], u[3], w[3], t;
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        t = $urandom_range(1 << 22, 1);
        if ($urandom_range(9) == 0) t = -t;
        for (int c = 0; c < 3; c++) begin
          pt[c] = longint'(ray_o[c]) + ((t * longint'(ray_d[c])) >>> 16);
          u[c] = $signed($urandom_range(1 << 19)) - (1 << 18);
          w[c] = $signed($urandom_range(1 << 19)) - (1 << 18);
          v[c]     = int'(pt[c] + u[c]);
          v[3 + c] = int'(pt[c] + w[c]);
          v[6 + c] = int'(pt[c] - u[c] - w[c]);
        end
      end else if (sel < 80) begin
        foreach (v[c]) v[c] = $urandom;
      end else begin
        foreach (v[c]) v[c] = $signed($urandom_range(1 << 21)) - (1 << 20);
      end
      send_triangle(v, $urandom_range(16'hFFFF));
    end
  endtask

  task automatic random_ray();
    int c3[6];
    foreach (c3[n]) c3[n] = $signed($urandom_range(1 << 21)) - (1 << 20);
    set_ray(c3[0], c3[1], c3[2], c3[3], c3[4], c3[5]);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    quiet = 1'b0;
    s_tvalid = 1'b0; s_tdata = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    ray_o = '{0, 0, 0};
    ray_d = '{0, 0, ONE};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed cases on the reset ray, origin 0 looking down +z
    tri_q(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE, 16'h0000);       // plain hit
    tri_q(-ONE, -ONE, -ONE, ONE, -ONE, -ONE, 0, ONE, -ONE, 16'hFFFF);    // behind origin
    tri_q(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 16'h0001);        // degenerate
    tri_q(ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE, 16'h0002);                // parallel plane
    tri_q(0, -ONE, ONE, 0, ONE, ONE, 2*ONE, 0, ONE, 16'h0003);           // on an edge
    tri_q(0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE, 16'h0004);                // on a vertex
    tri_q(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 16'h0005);             // t exactly 0
    tri_q(-ONE, -ONE, 1, ONE, -ONE, 1, 0, ONE, 1, 16'h0006);             // one lsb away
    tri_q(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0007);                          // all zero
    tri_q(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000);
    tri_q(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h7FFF);
    tri_q(32'h8000_0000, 0, ONE, 32'h7FFF_FFFF, 32'h8000_0000, ONE,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, ONE, 16'h00FF);                  // huge triangle
    random_triangles(150);

    // tiny direction: distance saturates
    set_ray(0, 0, 0, 0, 0, 1);
    tri_q(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE, 16'h0010);
    tri_q(-ONE, -ONE, 32'h7FFF_FFFF, ONE, -ONE, 32'h7FFF_FFFF, 0, ONE, 32'h7FFF_FFFF, 16'h0011);
    random_triangles(40);

    // huge direction: hit closer than one lsb
    set_ray(0, 0, 0, 0, 0, 32'h7FFF_FFFF);
    tri_q(-ONE, -ONE, 1, ONE, -ONE, 1, 0, ONE, 1, 16'h0012);
    random_triangles(40);

    // register extremes
    set_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    random_triangles(60);
    set_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    random_triangles(60);

    // random rays, one of them without any idling
    for (int r = 0; r < 4; r++) begin
      random_ray();
      quiet = (r == 1);
      random_triangles(190);
    end
    quiet = 1'b0;

    drain();
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
